>>> rtl/aes_pkg.sv
package aes_pkg;

    localparam int BLK_W  = 128;
    localparam int CFG_W  = 64;
    localparam int CNT_W  = 5;
    localparam int NRK    = 11;
    localparam int RK_AW  = 4;

    localparam logic [2:0] REG_KEY_HI = 3'd0;
    localparam logic [2:0] REG_KEY_LO = 3'd1;
    localparam logic [2:0] REG_IV_HI  = 3'd2;
    localparam logic [2:0] REG_IV_LO  = 3'd3;
    localparam logic [2:0] REG_DEC    = 3'd4;

    localparam logic [7:0] SBOX_AFF = 8'h63;
    localparam logic [7:0] INV_AFF  = 8'h05;

    typedef enum logic [3:0] {
        OP_LOAD  = 4'b0001,
        OP_FIRST = 4'b0010,
        OP_ROUND = 4'b0100,
        OP_LAST  = 4'b1000
    } t_rnd_op;

    typedef struct packed {
        logic    en;
        logic    dec;
        t_rnd_op op;
    } t_rnd_ctl;

    function automatic logic [7:0] xt(input logic [7:0] a);
        xt = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [7:0] gmul(input logic [7:0] a, input logic [3:0] b);
        logic [7:0] p;
        logic [7:0] x;
        p = '0;
        x = a;
        for (int i = 0; i < 4; i++) begin
            if (b[i]) p = p ^ x;
            x = xt(x);
        end
        gmul = p;
    endfunction

    function automatic logic [7:0] gfm(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] p;
        logic [7:0] x;
        p = '0;
        x = a;
        for (int i = 0; i < 8; i++) begin
            if (b[i]) p = p ^ x;
            x = xt(x);
        end
        gfm = p;
    endfunction

    function automatic logic [7:0] ginv(input logic [7:0] a);
        logic [7:0] r;
        logic [7:0] sq;
        // a^254 by square and multiply
        r = 8'h01;
        sq = a;
        for (int i = 1; i < 8; i++) begin
            sq = gfm(sq, sq);
            r = gfm(r, sq);
        end
        ginv = r;
    endfunction

    function automatic logic [7:0] sbox_calc(input logic [7:0] a);
        logic [7:0] b;
        logic [7:0] s;
        b = ginv(a);
        for (int i = 0; i < 8; i++)
            s[i] = b[i] ^ b[(i + 4) % 8] ^ b[(i + 5) % 8] ^ b[(i + 6) % 8]
                 ^ b[(i + 7) % 8] ^ SBOX_AFF[i];
        sbox_calc = s;
    endfunction

    function automatic logic [7:0] isbox_calc(input logic [7:0] a);
        logic [7:0] b;
        // inverse affine map, then field inverse
        for (int i = 0; i < 8; i++)
            b[i] = a[(i + 2) % 8] ^ a[(i + 5) % 8] ^ a[(i + 7) % 8] ^ INV_AFF[i];
        isbox_calc = ginv(b);
    endfunction

    function automatic logic [255:0][7:0] gen_box(input logic inv);
        logic [255:0][7:0] t;
        for (int i = 0; i < 256; i++)
            t[i] = inv ? isbox_calc(8'(i)) : sbox_calc(8'(i));
        return t;
    endfunction

    // substitution tables built at elaboration
    localparam logic [255:0][7:0] SBOX_T  = gen_box(1'b0);
    localparam logic [255:0][7:0] ISBOX_T = gen_box(1'b1);

    function automatic logic [7:0] sbox(input logic [7:0] a);
        sbox = SBOX_T[a];
    endfunction

    function automatic logic [7:0] isbox(input logic [7:0] a);
        isbox = ISBOX_T[a];
    endfunction

    function automatic logic [7:0] byte_of(input logic [127:0] s, input int i);
        byte_of = s[127 - 8 * i -: 8];
    endfunction

endpackage

>>> rtl/aes_stream_if.sv
interface aes_stream_if #(parameter int W = 1);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

>>> rtl/aes128_cbc_cipher_core.sv
// aes-128 cbc engine with pkcs7 padding
// input channel in_if carries {block_high, block_low, byte_count, last_block};
// output channel out_if carries {out_high, out_low, out_bytes, out_last, pad_error}
// config port: i_cfg_we, i_cfg_idx (0 key_high .. 4 decrypt_mode), i_cfg_data;
// write only while idle
// one round unit does one aes round per cycle; round keys come from an
// 11-entry store whose registered read is addressed ahead of use
// a taken request is loaded, then runs the key add and all rounds in the
// round state, and a finish state registers its result for the output
// the first block of a message waits for key expansion before it is taken;
// a full last encrypt block adds a padding block, which runs once the first
// result is taken
// output is held in a register until taken; no new request is taken
// until the previous result is accepted
// reset clears the sequencer, the message flag and the key, iv and mode
// registers; key store is rebuilt at each message start
module aes128_cbc_cipher_core
    import aes_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_we,
    input  logic [2:0]      i_cfg_idx,
    input  logic [CFG_W-1:0] i_cfg_data,
    aes_stream_if.sink      in_if,
    aes_stream_if.source    out_if
);
    typedef enum logic [5:0] {
        S_IDLE = 6'b000001, S_KEY = 6'b000010, S_PRE = 6'b000100,
        S_RUN = 6'b001000, S_FIN = 6'b010000, S_OUT = 6'b100000
    } t_state;

    t_state r_st;
    logic [BLK_W-1:0] r_key, r_iv, r_chain, r_blk, r_res;
    logic r_dec, r_inmsg, r_last, r_extra, r_rlast, r_perr;
    logic [CNT_W-1:0] r_rbytes;
    logic [RK_AW-1:0] r_rnd;
    logic [BLK_W-1:0] rk, st, pin;
    logic ks_busy, ks_start;
    t_rnd_ctl ctl;
    logic [BLK_W-1:0] dres, dz;
    logic [7:0] pv;
    logic pok;
    logic [RK_AW-1:0] raddr;

    always_ff @(posedge i_clk) begin
        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_KEY_HI: r_key[127:64] <= i_cfg_data;
                REG_KEY_LO: r_key[63:0] <= i_cfg_data;
                REG_IV_HI:  r_iv[127:64] <= i_cfg_data;
                REG_IV_LO:  r_iv[63:0] <= i_cfg_data;
                REG_DEC:    r_dec <= i_cfg_data[0];
                default: ;
            endcase
        end
        if (!i_rst_n) begin
            r_key <= '0;
            r_iv <= '0;
            r_dec <= 1'b0;
        end
    end

    // encrypt input with padding
    logic [4:0] n_cnt;
    always_comb begin
        n_cnt = in_if.data[0] ? ((in_if.data[5:1] > 5'd16) ? 5'd16 : in_if.data[5:1]) : 5'd16;
        for (int i = 0; i < 16; i++)
            pin[127 - 8 * i -: 8] = (5'(i) < n_cnt) ? byte_of(in_if.data[133:6], i)
                                                      : 8'(5'd16 - n_cnt);
    end

    assign ks_start = (r_st == S_IDLE) && in_if.valid && !r_inmsg;
    assign raddr = r_dec ? RK_AW'(NRK - 1) - r_rnd : r_rnd;

    aes_key_sched u_ks (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(ks_start), .i_key(r_key),
        .i_raddr(raddr), .o_rk(rk), .o_busy(ks_busy)
    );

    always_comb begin
        ctl.en = 1'b0;
        ctl.dec = r_dec;
        ctl.op = OP_LOAD;
        if (r_st == S_RUN) begin
            ctl.en = 1'b1;
            ctl.op = (r_rnd == RK_AW'(1)) ? OP_FIRST :
                     (r_rnd == RK_AW'(NRK)) ? OP_LAST : OP_ROUND;
        end else if (r_st == S_PRE) begin
            ctl.en = 1'b1;
        end
    end

    aes_round u_rnd (
        .i_clk(i_clk), .i_ctl(ctl),
        .i_load(r_dec ? r_blk : (r_blk ^ r_chain)),
        .i_rk(rk), .o_state(st)
    );

    always_comb begin
        dres = st ^ r_chain;
        pv = dres[7:0];
        pok = (pv >= 8'd1) && (pv <= 8'd16);
        for (int i = 0; i < 16; i++)
            if (8'(i) < pv && dres[8 * i +: 8] != pv) pok = 1'b0;
        for (int i = 0; i < 16; i++)
            dz[8 * i +: 8] = (8'(i) < pv) ? 8'h00 : dres[8 * i +: 8];
    end

    // the first request of a message is held off until its keys are built
    assign in_if.ready = (r_st == S_IDLE) && r_inmsg;
    assign out_if.valid = (r_st == S_OUT);
    assign out_if.data = {r_res, r_rbytes, r_rlast, r_perr};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE;
            r_inmsg <= 1'b0;
        end else begin
            unique case (r_st)
                S_IDLE: if (in_if.valid) begin
                    if (!r_inmsg) begin
                        r_chain <= r_iv;
                        r_st <= S_KEY;
                    end else begin
                        r_blk <= r_dec ? in_if.data[133:6] : pin;
                        r_last <= in_if.data[0];
                        r_extra <= !r_dec && in_if.data[0] && (n_cnt == 5'd16);
                        r_inmsg <= !in_if.data[0];
                        r_rnd <= '0;
                        r_st <= S_PRE;
                    end
                end
                S_KEY: if (!ks_busy) begin
                    r_inmsg <= 1'b1;
                    r_st <= S_IDLE;
                end
                S_PRE: begin
                    r_rnd <= r_rnd + 1'b1;
                    r_st <= S_RUN;
                end
                S_RUN: begin
                    r_rnd <= r_rnd + 1'b1;
                    if (r_rnd == RK_AW'(NRK)) r_st <= S_FIN;
                end
                S_FIN: begin
                    r_perr <= 1'b0;
                    r_rbytes <= 5'd16;
                    r_rlast <= r_last && !r_extra;
                    if (r_dec) begin
                        r_chain <= r_blk;
                        r_res <= dres;
                        if (r_last) begin
                            r_res <= pok ? dz : '0;
                            r_perr <= !pok;
                            r_rbytes <= pok ? 5'(8'd16 - pv) : 5'd0;
                        end
                    end else begin
                        r_chain <= st;
                        r_res <= st;
                    end
                    r_st <= S_OUT;
                end
                S_OUT: if (out_if.ready) begin
                    if (r_extra) begin
                        r_extra <= 1'b0;
                        r_blk <= {16{8'h10}};
                        r_rnd <= '0;
                        r_st <= S_PRE;
                    end else begin
                        r_st <= S_IDLE;
                    end
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end
endmodule

>>> rtl/aes_round.sv
module aes_round
    import aes_pkg::*;
(
    input  logic                i_clk,
    input  t_rnd_ctl            i_ctl,
    input  logic [BLK_W-1:0]    i_load,
    input  logic [BLK_W-1:0]    i_rk,
    output logic [BLK_W-1:0]    o_state
);
    logic [BLK_W-1:0] r_s;
    logic [BLK_W-1:0] n_s;
    logic [BLK_W-1:0] sb;
    logic [BLK_W-1:0] sr;
    logic [BLK_W-1:0] mx;
    logic [BLK_W-1:0] ak;

    always_comb begin
        for (int i = 0; i < 16; i++) begin
            sb[127 - 8 * i -: 8] = i_ctl.dec ? isbox(byte_of(r_s, i)) : sbox(byte_of(r_s, i));
        end
        for (int r = 0; r < 4; r++)
            for (int c = 0; c < 4; c++)
                sr[127 - 8 * (r + 4 * c) -: 8] = i_ctl.dec ?
                    byte_of(sb, r + 4 * ((c + 4 - r) % 4)) : byte_of(sb, r + 4 * ((c + r) % 4));
        ak = sr ^ i_rk;
        for (int c = 0; c < 4; c++) begin
            logic [7:0] a0, a1, a2, a3;
            logic [BLK_W-1:0] src;
            src = i_ctl.dec ? ak : sr;
            a0 = byte_of(src, 4 * c);
            a1 = byte_of(src, 4 * c + 1);
            a2 = byte_of(src, 4 * c + 2);
            a3 = byte_of(src, 4 * c + 3);
            if (i_ctl.dec) begin
                mx[127 - 32 * c -: 8] = gmul(a0, 4'd14) ^ gmul(a1, 4'd11) ^ gmul(a2, 4'd13)
                                      ^ gmul(a3, 4'd9);
                mx[119 - 32 * c -: 8] = gmul(a0, 4'd9) ^ gmul(a1, 4'd14) ^ gmul(a2, 4'd11)
                                      ^ gmul(a3, 4'd13);
                mx[111 - 32 * c -: 8] = gmul(a0, 4'd13) ^ gmul(a1, 4'd9) ^ gmul(a2, 4'd14)
                                      ^ gmul(a3, 4'd11);
                mx[103 - 32 * c -: 8] = gmul(a0, 4'd11) ^ gmul(a1, 4'd13) ^ gmul(a2, 4'd9)
                                      ^ gmul(a3, 4'd14);
            end else begin
                mx[127 - 32 * c -: 8] = xt(a0) ^ xt(a1) ^ a1 ^ a2 ^ a3;
                mx[119 - 32 * c -: 8] = a0 ^ xt(a1) ^ xt(a2) ^ a2 ^ a3;
                mx[111 - 32 * c -: 8] = a0 ^ a1 ^ xt(a2) ^ xt(a3) ^ a3;
                mx[103 - 32 * c -: 8] = xt(a0) ^ a0 ^ a1 ^ a2 ^ xt(a3);
            end
        end
        n_s = r_s;
        unique case (i_ctl.op)
            OP_LOAD:  n_s = i_load;
            OP_FIRST: n_s = r_s ^ i_rk;
            OP_ROUND: n_s = i_ctl.dec ? mx : (mx ^ i_rk);
            OP_LAST:  n_s = ak;
            default:  n_s = r_s;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) r_s <= n_s;
    end

    assign o_state = r_s;
endmodule

>>> rtl/aes_key_sched.sv
module aes_key_sched
    import aes_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [BLK_W-1:0]    i_key,
    input  logic [RK_AW-1:0]    i_raddr,
    output logic [BLK_W-1:0]    o_rk,
    output logic                o_busy
);
    logic [BLK_W-1:0] r_mem [NRK];
    logic [BLK_W-1:0] r_k;
    logic [BLK_W-1:0] n_k;
    logic [RK_AW-1:0] r_idx;
    logic [7:0]       r_rc;
    logic             r_busy;
    logic [31:0]      t;
    logic [31:0]      w0, w1, w2, w3;

    always_comb begin
        t = {sbox(r_k[23:16]) ^ r_rc, sbox(r_k[15:8]), sbox(r_k[7:0]), sbox(r_k[31:24])};
        w0 = r_k[127:96] ^ t;
        w1 = r_k[95:64] ^ w0;
        w2 = r_k[63:32] ^ w1;
        w3 = r_k[31:0] ^ w2;
        n_k = {w0, w1, w2, w3};
    end

    // one round key per cycle, written as it is made
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_start) begin
            r_k <= i_key;
            r_idx <= '0;
            r_rc <= 8'h01;
            r_busy <= 1'b1;
        end else if (r_busy) begin
            r_mem[r_idx] <= r_k;
            r_k <= n_k;
            r_rc <= xt(r_rc);
            r_idx <= r_idx + 1'b1;
            if (r_idx == RK_AW'(NRK - 1)) r_busy <= 1'b0;
        end
        o_rk <= r_mem[i_raddr];
    end

    assign o_busy = r_busy;
endmodule

>>> rtl/aes_cbc_checker.sv
module aes_cbc_checker
    import aes_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [134:0] out_data
);
    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && out_data[0] |-> out_data[6:2] == 5'd0 && out_data[1])
        else $error("pad error without zero count");
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid |-> !in_ready) else $error("input taken while result pending");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result dropped");
    a_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid |-> out_data[6:2] <= 5'd16) else $error("bad count");
endmodule

bind aes128_cbc_cipher_core aes_cbc_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .in_valid(in_if.valid), .in_ready(in_if.ready),
    .out_valid(out_if.valid), .out_ready(out_if.ready), .out_data(out_if.data)
);

>>> sim/tb_aes128_cbc_cipher_core.sv
module tb_aes128_cbc_cipher_core
    import aes_pkg::*;
();

    localparam int          IN_W      = 134;
    localparam int          OUT_W     = 135;
    localparam int          N_ITEMS   = 1200;
    localparam int          CYC_LIMIT = 1000000;
    localparam logic [2:0]  REG_SPARE = 3'd5;

    typedef logic [10:0][127:0] t_sched;

    typedef struct {
        logic [63:0] hi;
        logic [63:0] lo;
        logic [4:0]  nbytes;
        logic        last;
        logic        err;
    } t_block_res;

    typedef struct {
        logic [63:0] hi;
        logic [63:0] lo;
        logic [4:0]  cnt;
        logic        last;
        bit          typed;
        t_block_res  want;
    } t_dir_row;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [2:0] i_cfg_idx;
    logic [CFG_W-1:0] i_cfg_data;

    aes_stream_if #(.W(IN_W))  in_if ();
    aes_stream_if #(.W(OUT_W)) out_if ();

    aes128_cbc_cipher_core u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .in_if      (in_if),
        .out_if     (out_if)
    );

    logic [7:0] fwd_sb [256];
    logic [7:0] inv_sb [256];

    // shadow of the block's registers and message state
    logic [127:0] key_reg, iv_reg, chain_reg;
    logic         dec_reg;
    logic         msg_open;
    t_sched       sched;

    t_block_res   blocks_due [$];
    int           fail_cnt = 0;
    int           sent_cnt;
    int           src_pct, snk_pct;
    int           cycle_cnt = 0;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic logic [7:0] gmul8(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] p;
        p = '0;
        for (int i = 0; i < 8; i++) begin
            if (b[i]) p = p ^ a;
            a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
        end
        return p;
    endfunction

    function automatic logic [7:0] rotl8(input logic [7:0] b, input int n);
        return (b << n) | (b >> (8 - n));
    endfunction

    function automatic logic [7:0] byte_at(input logic [127:0] v, input int i);
        return v[127 - 8 * i -: 8];
    endfunction

    function automatic t_sched expand_key(input logic [127:0] k);
        logic [7:0] w [176];
        logic [7:0] t [4];
        logic [7:0] x, rc;
        t_sched r;
        rc = 8'h01;
        for (int i = 0; i < 16; i++) w[i] = byte_at(k, i);
        for (int i = 4; i < 44; i++) begin
            for (int j = 0; j < 4; j++) t[j] = w[(i - 1) * 4 + j];
            if (i % 4 == 0) begin
                x = t[0];
                t[0] = fwd_sb[t[1]] ^ rc;
                t[1] = fwd_sb[t[2]];
                t[2] = fwd_sb[t[3]];
                t[3] = fwd_sb[x];
                rc = gmul8(rc, 8'h02);
            end
            for (int j = 0; j < 4; j++) w[i * 4 + j] = w[(i - 4) * 4 + j] ^ t[j];
        end
        for (int n = 0; n < 11; n++)
            for (int j = 0; j < 16; j++) r[n][127 - 8 * j -: 8] = w[16 * n + j];
        return r;
    endfunction

    function automatic logic [127:0] encipher(input t_sched rk, input logic [127:0] b);
        logic [7:0] s [16];
        logic [7:0] t [16];
        logic [7:0] a0, a1, a2, a3;
        for (int i = 0; i < 16; i++) s[i] = byte_at(b ^ rk[0], i);
        for (int r = 1; r <= 10; r++) begin
            for (int i = 0; i < 16; i++) s[i] = fwd_sb[s[i]];
            for (int w = 0; w < 4; w++)
                for (int c = 0; c < 4; c++) t[w + 4 * c] = s[w + 4 * ((c + w) % 4)];
            s = t;
            if (r < 10) begin
                for (int c = 0; c < 4; c++) begin
                    a0 = s[4*c]; a1 = s[4*c+1]; a2 = s[4*c+2]; a3 = s[4*c+3];
                    s[4*c]   = gmul8(a0, 8'd2) ^ gmul8(a1, 8'd3) ^ a2 ^ a3;
                    s[4*c+1] = a0 ^ gmul8(a1, 8'd2) ^ gmul8(a2, 8'd3) ^ a3;
                    s[4*c+2] = a0 ^ a1 ^ gmul8(a2, 8'd2) ^ gmul8(a3, 8'd3);
                    s[4*c+3] = gmul8(a0, 8'd3) ^ a1 ^ a2 ^ gmul8(a3, 8'd2);
                end
            end
            for (int i = 0; i < 16; i++) s[i] = s[i] ^ byte_at(rk[r], i);
        end
        for (int i = 0; i < 16; i++) b[127 - 8 * i -: 8] = s[i];
        return b;
    endfunction

    function automatic logic [127:0] decipher(input t_sched rk, input logic [127:0] b);
        logic [7:0] s [16];
        logic [7:0] t [16];
        logic [7:0] a0, a1, a2, a3;
        for (int i = 0; i < 16; i++) s[i] = byte_at(b ^ rk[10], i);
        for (int r = 9; r >= 0; r--) begin
            for (int w = 0; w < 4; w++)
                for (int c = 0; c < 4; c++) t[w + 4 * c] = s[w + 4 * ((c + 4 - w) % 4)];
            s = t;
            for (int i = 0; i < 16; i++) s[i] = inv_sb[s[i]] ^ byte_at(rk[r], i);
            if (r > 0) begin
                for (int c = 0; c < 4; c++) begin
                    a0 = s[4*c]; a1 = s[4*c+1]; a2 = s[4*c+2]; a3 = s[4*c+3];
                    s[4*c]   = gmul8(a0, 8'd14) ^ gmul8(a1, 8'd11) ^ gmul8(a2, 8'd13)
                             ^ gmul8(a3, 8'd9);
                    s[4*c+1] = gmul8(a0, 8'd9) ^ gmul8(a1, 8'd14) ^ gmul8(a2, 8'd11)
                             ^ gmul8(a3, 8'd13);
                    s[4*c+2] = gmul8(a0, 8'd13) ^ gmul8(a1, 8'd9) ^ gmul8(a2, 8'd14)
                             ^ gmul8(a3, 8'd11);
                    s[4*c+3] = gmul8(a0, 8'd11) ^ gmul8(a1, 8'd13) ^ gmul8(a2, 8'd9)
                             ^ gmul8(a3, 8'd14);
                end
            end
        end
        for (int i = 0; i < 16; i++) b[127 - 8 * i -: 8] = s[i];
        return b;
    endfunction

    // works out the result blocks of one accepted request
    task automatic predict_blocks(input logic [63:0] hi, input logic [63:0] lo,
                                  input logic [4:0] cnt, input logic last);
        logic [127:0] d, prev;
        t_block_res   res;
        int           n, p;
        bit           ok;
        if (!msg_open) begin
            sched = expand_key(key_reg);
            chain_reg = iv_reg;
            msg_open = 1'b1;
        end
        if (last) msg_open = 1'b0;
        d = {hi, lo};
        res.err = 1'b0;
        if (!dec_reg) begin
            n = 16;
            if (last) n = (cnt > 16) ? 16 : int'(cnt);
            for (int i = n; i < 16; i++) d[127 - 8 * i -: 8] = 8'(16 - n);
            chain_reg = encipher(sched, d ^ chain_reg);
            {res.hi, res.lo} = chain_reg;
            res.nbytes = 5'd16;
            res.last = last && (n != 16);
            blocks_due.push_back(res);
            if (last && n == 16) begin
                chain_reg = encipher(sched, {16{8'h10}} ^ chain_reg);
                {res.hi, res.lo} = chain_reg;
                res.last = 1'b1;
                blocks_due.push_back(res);
            end
        end else begin
            prev = chain_reg;
            chain_reg = d;
            d = decipher(sched, d) ^ prev;
            res.nbytes = 5'd16;
            res.last = last;
            if (last) begin
                p = int'(d[7:0]);
                ok = (p >= 1 && p <= 16);
                for (int i = 0; ok && i < p; i++)
                    if (byte_at(d, 15 - i) != 8'(p)) ok = 0;
                if (!ok) begin
                    d = '0;
                    res.nbytes = 5'd0;
                    res.err = 1'b1;
                end else begin
                    for (int i = 16 - p; i < 16; i++) d[127 - 8 * i -: 8] = 8'h00;
                    res.nbytes = 5'(16 - p);
                end
            end
            {res.hi, res.lo} = d;
            blocks_due.push_back(res);
        end
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [63:0] v);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= v;
        @(posedge i_clk);
        case (idx)
            REG_KEY_HI: key_reg[127:64] = v;
            REG_KEY_LO: key_reg[63:0]   = v;
            REG_IV_HI:  iv_reg[127:64]  = v;
            REG_IV_LO:  iv_reg[63:0]    = v;
            REG_DEC:    dec_reg         = v[0];
            default: ;
        endcase
    endtask

    task automatic load_setup(input logic [127:0] k, input logic [127:0] iv, input logic dec);
        // no request may wait while the registers change
        in_if.valid <= 1'b0;
        while (blocks_due.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        write_reg(REG_KEY_HI, k[127:64]);
        write_reg(REG_KEY_LO, k[63:0]);
        write_reg(REG_IV_HI, iv[127:64]);
        write_reg(REG_IV_LO, iv[63:0]);
        write_reg(REG_SPARE + 3'($urandom_range(0, 2)), {$urandom, $urandom});
        write_reg(REG_DEC, {63'($urandom), dec});
        i_cfg_we <= 1'b0;
    endtask

    // hands one request to the block and predicts it once accepted
    task automatic send_request(input logic [63:0] hi, input logic [63:0] lo,
                                input logic [4:0] cnt, input logic last);
        if (sent_cnt < N_ITEMS / 3) begin
            src_pct = 9;  snk_pct = 87;
        end else if (sent_cnt < 2 * N_ITEMS / 3) begin
            src_pct = 87; snk_pct = 9;
        end else begin
            src_pct = 0;  snk_pct = 0;
        end
        while ($urandom_range(0, 99) < src_pct) begin
            in_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_if.valid <= 1'b1;
        in_if.data  <= {hi, lo, cnt, last};
        do @(posedge i_clk); while (!in_if.ready);
        predict_blocks(hi, lo, cnt, last);
        sent_cnt++;
    endtask

    // well-formed ciphertext message built from padded plaintext; mangle breaks the pad
    task automatic send_cipher_msg(input int nblk, input int pad, input int mangle);
        t_sched       rk;
        logic [127:0] c, pt;
        rk = expand_key(key_reg);
        c = iv_reg;
        for (int b = 0; b < nblk; b++) begin
            pt = {$urandom, $urandom, $urandom, $urandom};
            if (b == nblk - 1) begin
                for (int i = 16 - pad; i < 16; i++) pt[127 - 8 * i -: 8] = 8'(pad);
                case (mangle)
                    1: pt[7:0] = 8'h00;
                    2: pt[7:0] = 8'($urandom_range(17, 255));
                    3: if (pad > 1) pt[127 - 8 * (16 - pad) -: 8] ^= 8'($urandom_range(1, 255));
                       else pt[7:0] = 8'h00;
                    default: ;
                endcase
            end
            c = encipher(rk, pt ^ c);
            send_request(c[127:64], c[63:0], 5'($urandom), b == nblk - 1);
        end
    endtask

    task automatic send_plain_msg(input int nblk);
        for (int b = 0; b < nblk; b++)
            send_request({$urandom, $urandom}, {$urandom, $urandom},
                         5'($urandom_range(0, 31)), b == nblk - 1);
    endtask

    task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
        if (want !== got) begin
            $error("%s: expected %h, got %h", name, want, got);
            fail_cnt++;
        end
    endtask

    // result side: random stalls and comparison against the oldest prediction
    always @(posedge i_clk) begin
        t_block_res want;
        logic [63:0] g_hi, g_lo;
        logic [4:0]  g_n;
        logic        g_last, g_err;
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
        end else begin
            out_if.ready <= ($urandom_range(0, 99) >= snk_pct);
            if (out_if.valid && out_if.ready) begin
                {g_hi, g_lo, g_n, g_last, g_err} = out_if.data;
                if (blocks_due.size() == 0) begin
                    $error("result block with nothing outstanding: %h %h", g_hi, g_lo);
                    fail_cnt++;
                end else begin
                    want = blocks_due.pop_front();
                    check_field("out_high", want.hi, g_hi);
                    check_field("out_low", want.lo, g_lo);
                    check_field("out_bytes", 64'(want.nbytes), 64'(g_n));
                    check_field("out_last", 64'(want.last), 64'(g_last));
                    check_field("pad_error", 64'(want.err), 64'(g_err));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYC_LIMIT) begin
            $display("tb_aes128_cbc_cipher_core: done, errors");
            $finish;
        end
    end

    initial begin
        t_dir_row     dir_rows [$];
        t_dir_row     row;
        logic [127:0] rk, riv;
        int           x, y, nblk, pad;
        bit           found;

        i_rst_n     <= 1'b0;
        i_cfg_we    <= 1'b0;
        i_cfg_idx   <= REG_KEY_HI;
        i_cfg_data  <= '0;
        in_if.valid <= 1'b0;
        in_if.data  <= '0;
        sent_cnt = 0;
        src_pct = 9; snk_pct = 87;
        key_reg = '0; iv_reg = '0; chain_reg = '0; dec_reg = 1'b0; msg_open = 1'b0;

        // substitution tables from the field inverse and the affine map
        for (int a = 0; a < 256; a++) begin
            x = 0;
            found = 0;
            for (int b = 1; b < 256 && !found; b++)
                if (gmul8(8'(a), 8'(b)) == 8'h01) begin
                    x = b;
                    found = 1;
                end
            y = int'(8'(x) ^ rotl8(8'(x), 1) ^ rotl8(8'(x), 2) ^ rotl8(8'(x), 3)
                ^ rotl8(8'(x), 4) ^ 8'h63);
            fwd_sb[a] = 8'(y);
            inv_sb[y] = 8'(a);
        end

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // encrypt: standard test key, zero chaining start
        load_setup(128'h000102030405060708090a0b0c0d0e0f, '0, 1'b0);
        row = '{hi: 64'h0011223344556677, lo: 64'h8899aabbccddeeff, cnt: 5'd0, last: 1'b0,
                typed: 1'b1, want: '{64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a, 5'd16,
                1'b0, 1'b0}};
        dir_rows.push_back(row);
        row.typed = 0;
        row.hi = '1; row.lo = '1; row.cnt = 5'd16; row.last = 1; dir_rows.push_back(row);
        row.hi = '0; row.lo = '0; row.cnt = 5'd0;  dir_rows.push_back(row);
        row.hi = 64'h0123456789abcdef; row.lo = 64'hfedcba9876543210;
        row.cnt = 5'd31; dir_rows.push_back(row);
        row.cnt = 5'd17; dir_rows.push_back(row);
        row.cnt = 5'd5;  dir_rows.push_back(row);
        row.cnt = 5'd15; dir_rows.push_back(row);
        row.cnt = 5'd1;  dir_rows.push_back(row);
        row.cnt = 5'd0;  row.last = 0; dir_rows.push_back(row);
        row.cnt = 5'd31; dir_rows.push_back(row);
        row.cnt = 5'd16; row.last = 1; dir_rows.push_back(row);
        foreach (dir_rows[i]) begin
            send_request(dir_rows[i].hi, dir_rows[i].lo, dir_rows[i].cnt, dir_rows[i].last);
            if (dir_rows[i].typed) blocks_due[$] = dir_rows[i].want;
        end

        // decrypt: all-ones key and iv, good pads, bad pads, raw extremes
        load_setup('1, '1, 1'b1);
        send_request('0, '0, 5'd0, 1'b1);
        send_request('1, '1, 5'd31, 1'b1);
        send_cipher_msg(1, 1, 0);
        send_cipher_msg(2, 16, 0);
        send_cipher_msg(1, 7, 0);
        send_cipher_msg(1, 4, 1);
        send_cipher_msg(1, 4, 2);
        send_cipher_msg(2, 9, 3);

        // random phases, alternating direction, extremes on some
        for (int ph = 0; sent_cnt < N_ITEMS + 25; ph++) begin
            case (ph % 6)
                0: begin rk = '0; riv = '0; end
                3: begin rk = '1; riv = '1; end
                default: begin
                    rk  = {$urandom, $urandom, $urandom, $urandom};
                    riv = {$urandom, $urandom, $urandom, $urandom};
                end
            endcase
            load_setup(rk, riv, ph[0]);
            for (int m = 0; m < 40; m++) begin
                nblk = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : $urandom_range(1, 2);
                if (!dec_reg) begin
                    send_plain_msg(nblk);
                end else begin
                    x = $urandom_range(0, 99);
                    pad = $urandom_range(1, 16);
                    if (x < 70)      send_cipher_msg(nblk, pad, 0);
                    else if (x < 85) send_cipher_msg(nblk, pad, $urandom_range(1, 3));
                    else             send_plain_msg(nblk);
                end
            end
        end
        in_if.valid <= 1'b0;

        while (blocks_due.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (fail_cnt == 0 && blocks_due.size() == 0) begin
            $display("tb_aes128_cbc_cipher_core: done, clean");
        end else begin
            $display("tb_aes128_cbc_cipher_core: done, errors");
        end
        $finish;
    end

endmodule

>>> files.f
rtl/aes_pkg.sv
rtl/aes_stream_if.sv
rtl/aes_round.sv
rtl/aes_key_sched.sv
rtl/aes128_cbc_cipher_core.sv
rtl/aes_cbc_checker.sv
sim/tb_aes128_cbc_cipher_core.sv
